@@ hw/rtl/rthc_pkg.sv @@
// ----------------------------------------------------------------------------
// rthc_pkg
// Types and constants shared by the RGB to HSL conversion pipeline.
// ----------------------------------------------------------------------------
package rthc_pkg;

  localparam int CH_W       = 16;
  localparam int THR_W      = 16;
  localparam int DIV_W      = CH_W + 3;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (CH_W + DIV_STEP - 1) / DIV_STEP;
  localparam int FRONT_STG  = 3;
  localparam int NSTG       = FRONT_STG + DIV_STAGES + 1;

  localparam logic [CH_W-1:0] CH_FULL = {CH_W{1'b1}};

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rthc_sector_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rthc_pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] lightness;
  } rthc_hsl_t;

  typedef struct packed {
    logic [CH_W-1:0]  light;
    logic             gray;
    logic [CH_W-1:0]  sat_hi;
    logic [CH_W-1:0]  sat_lo;
    logic [CH_W-1:0]  sat_den;
    logic [DIV_W-1:0] hue_num;
    logic [DIV_W-1:0] hue_den;
  } rthc_prep_t;

endpackage

@@ hw/rtl/rthc_front.sv @@
// ----------------------------------------------------------------------------
// rthc_front
// Three register stages: max/min and sector, spread and sum, then
// lightness, gray flag and the operands of both dividers.
// ----------------------------------------------------------------------------
module rthc_front (
  input  logic                           clk_i,
  input  logic [rthc_pkg::FRONT_STG-1:0] en_i,
  input  rthc_pkg::rthc_pixel_t          pixel_i,
  input  logic [rthc_pkg::CH_W-1:0]      thr_i,
  output rthc_pkg::rthc_prep_t           prep_o
);
  import rthc_pkg::*;

  localparam int SW = DIV_W + 1;

  logic [CH_W-1:0] mx_d, mx_q, mn_d, mn_q;
  rthc_sector_e    seca_d, seca_q, secb_q;
  logic [CH_W:0]   difa_d, difa_q, difb_q;
  logic [CH_W-1:0] spread_d, spread_q;
  logic [CH_W:0]   sum_d, sum_q;
  rthc_prep_t      prep_d, prep_q;

  logic [DIV_W-1:0]  s6, off;
  logic [SW-1:0]     num_s;
  logic [2*CH_W-1:0] nsat;
  logic [CH_W:0]     two_full;

  // stage A
  always_comb begin
    logic [CH_W-1:0] r, g, b;
    r = pixel_i.red;
    g = pixel_i.green;
    b = pixel_i.blue;
    if (r >= g && r >= b) begin
      seca_d = SEC_RED;
      mx_d   = r;
      difa_d = {1'b0, g} - {1'b0, b};
    end else if (g >= b) begin
      seca_d = SEC_GREEN;
      mx_d   = g;
      difa_d = {1'b0, b} - {1'b0, r};
    end else begin
      seca_d = SEC_BLUE;
      mx_d   = b;
      difa_d = {1'b0, r} - {1'b0, g};
    end
    if (r <= g && r <= b) begin
      mn_d = r;
    end else if (g <= b) begin
      mn_d = g;
    end else begin
      mn_d = b;
    end
  end

  // stage B
  assign spread_d = mx_q - mn_q;
  assign sum_d    = {1'b0, mx_q} + {1'b0, mn_q};

  // stage C
  assign two_full = {CH_FULL, 1'b0};
  assign nsat     = {spread_q, {CH_W{1'b0}}} - {{CH_W{1'b0}}, spread_q};
  assign s6       = DIV_W'({spread_q, 2'b00}) + DIV_W'({spread_q, 1'b0});

  always_comb begin
    case (secb_q)
      SEC_RED:   off = difb_q[CH_W] ? s6 : '0;
      SEC_GREEN: off = DIV_W'({spread_q, 1'b0});
      SEC_BLUE:  off = DIV_W'({spread_q, 2'b00});
      default:   off = '0;
    endcase
  end

  assign num_s = {1'b0, off} + {{(SW-CH_W-1){difb_q[CH_W]}}, difb_q};

  always_comb begin
    prep_d.light   = sum_q[CH_W:1];
    prep_d.gray    = (spread_q <= thr_i);
    prep_d.sat_hi  = nsat[2*CH_W-1:CH_W];
    prep_d.sat_lo  = nsat[CH_W-1:0];
    prep_d.sat_den = (sum_q > {1'b0, CH_FULL}) ? CH_W'(two_full - sum_q)
                                                : sum_q[CH_W-1:0];
    prep_d.hue_num = num_s[DIV_W-1:0];
    prep_d.hue_den = s6;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mx_q   <= mx_d;
      mn_q   <= mn_d;
      seca_q <= seca_d;
      difa_q <= difa_d;
    end
    if (en_i[1]) begin
      spread_q <= spread_d;
      sum_q    <= sum_d;
      secb_q   <= seca_q;
      difb_q   <= difa_q;
    end
    if (en_i[2]) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

@@ hw/rtl/rthc_div.sv @@
// ----------------------------------------------------------------------------
// rthc_div
// Pipelined restoring divider: DIV_STEP quotient bits per register stage.
// Requires num_hi_i < den_i; the quotient then fits in CH_W bits.
// ----------------------------------------------------------------------------
module rthc_div (
  input  logic                            clk_i,
  input  logic [rthc_pkg::DIV_STAGES-1:0] en_i,
  input  logic [rthc_pkg::DIV_W-1:0]      num_hi_i,
  input  logic [rthc_pkg::CH_W-1:0]       num_lo_i,
  input  logic [rthc_pkg::DIV_W-1:0]      den_i,
  output logic [rthc_pkg::CH_W-1:0]       quo_o
);
  import rthc_pkg::*;

  logic [DIV_W-1:0] rem_q [DIV_STAGES];
  logic [CH_W-1:0]  wrd_q [DIV_STAGES];
  logic [DIV_W-1:0] den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0] rem_in, den_in, rem_d;
    logic [CH_W-1:0]  wrd_in, wrd_d;

    if (k == 0) begin : g_first
      assign rem_in = num_hi_i;
      assign wrd_in = num_lo_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign wrd_in = wrd_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      logic [DIV_W:0] t;
      logic           q;
      rem_d = rem_in;
      wrd_d = wrd_in;
      for (int s = 0; s < DIV_STEP; s++) begin
        if (k * DIV_STEP + s < CH_W) begin
          t = {rem_d, wrd_d[CH_W-1]};
          if (t >= {1'b0, den_in}) begin
            t = t - {1'b0, den_in};
            q = 1'b1;
          end else begin
            q = 1'b0;
          end
          rem_d = t[DIV_W-1:0];
          wrd_d = {wrd_d[CH_W-2:0], q};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        wrd_q[k] <= wrd_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = wrd_q[DIV_STAGES-1];

endmodule

@@ hw/rtl/rgb_to_hsl_convert_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_core
// RGB to HSL pixel conversion with programmable gray threshold.
//
//   channel  | valid        | stall        | data
//   ---------+--------------+--------------+--------------------------
//   input    | in_valid_i   | in_stall_o   | in_pixel_i  (red/green/blue)
//   output   | out_valid_o  | out_stall_i  | out_hsl_o   (hue/sat/light)
//   config   | cfg_we_i     | -            | cfg_wdata_i (gray threshold)
//
// One word per cycle sustained while out_stall_i is low. The NSTG (12)
// stages are three front stages, the two parallel 8-stage dividers and
// the output register. Each stage advances when it is empty or the next
// one advances, so bubbles fill while the output is stalled. Reset empties
// the pipeline and clears the threshold to zero.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rthc_pkg::THR_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rthc_pkg::rthc_pixel_t             in_pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rthc_pkg::rthc_hsl_t               out_hsl_o
);
  import rthc_pkg::*;

  logic [CH_W-1:0] thr_d, thr_q;
  logic [NSTG-1:0] v_d, v_q;
  logic [NSTG:0]   rdy;
  rthc_prep_t      prep;
  logic [CH_W-1:0] sat_quo, hue_quo;
  logic [CH_W-1:0] lt_q [DIV_STAGES];
  logic            gy_q [DIV_STAGES];
  rthc_hsl_t       hsl_d, hsl_q;

  assign thr_d = cfg_we_i ? CH_W'(cfg_wdata_i) : thr_q;

  always_comb begin
    rdy[NSTG] = !out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NSTG; k++) begin
      if (!rdy[k]) begin
        v_d[k] = v_q[k];
      end else if (k == 0) begin
        v_d[k] = in_valid_i;
      end else begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      v_q   <= '0;
    end else begin
      thr_q <= thr_d;
      v_q   <= v_d;
    end
  end

  rthc_front u_front (
    .clk_i   (clk_i),
    .en_i    (rdy[FRONT_STG-1:0]),
    .pixel_i (in_pixel_i),
    .thr_i   (thr_q),
    .prep_o  (prep)
  );

  rthc_div u_div_sat (
    .clk_i    (clk_i),
    .en_i     (rdy[FRONT_STG +: DIV_STAGES]),
    .num_hi_i (DIV_W'(prep.sat_hi)),
    .num_lo_i (prep.sat_lo),
    .den_i    (DIV_W'(prep.sat_den)),
    .quo_o    (sat_quo)
  );

  rthc_div u_div_hue (
    .clk_i    (clk_i),
    .en_i     (rdy[FRONT_STG +: DIV_STAGES]),
    .num_hi_i (prep.hue_num),
    .num_lo_i ('0),
    .den_i    (prep.hue_den),
    .quo_o    (hue_quo)
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
    logic [CH_W-1:0] lt_in;
    logic            gy_in;

    if (k == 0) begin : g_first
      assign lt_in = prep.light;
      assign gy_in = prep.gray;
    end else begin : g_next
      assign lt_in = lt_q[k-1];
      assign gy_in = gy_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (rdy[FRONT_STG + k]) begin
        lt_q[k] <= lt_in;
        gy_q[k] <= gy_in;
      end
    end
  end

  always_comb begin
    hsl_d.lightness  = lt_q[DIV_STAGES-1];
    hsl_d.hue        = gy_q[DIV_STAGES-1] ? '0 : hue_quo;
    hsl_d.saturation = gy_q[DIV_STAGES-1] ? '0 : sat_quo;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-1]) begin
      hsl_q <= hsl_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_hsl_o   = hsl_q;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with a bubble in the pipeline");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted word not captured in first stage");

  a_front_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[FRONT_STG-1] && rdy[FRONT_STG] |=> v_q[FRONT_STG])
    else $error("word lost between front end and dividers");

  a_zero_den_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[FRONT_STG-1] && prep.sat_den == '0 |-> prep.gray)
    else $error("zero saturation divisor on a non-gray pixel");
`endif

endmodule

@@ tb/rthc_hsl_checker.sv @@
// ----------------------------------------------------------------------------
// rthc_hsl_checker
// Watches the pixel, HSL and threshold ports of the RGB to HSL core. Each
// accepted pixel is converted here at the current gray threshold. Each
// accepted HSL word is checked field by field against the oldest pending
// conversion. Reports the error count and the number of words still due.
// ----------------------------------------------------------------------------
module rthc_hsl_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rthc_pkg::THR_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  rthc_pkg::rthc_pixel_t       in_pixel_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  rthc_pkg::rthc_hsl_t         out_hsl_i,
  output int                          err_cnt_o,
  output int                          due_cnt_o
);
  import rthc_pkg::*;

  localparam int MAX_LINES = 40;

  logic [CH_W-1:0] gray_thr = '0;
  rthc_hsl_t       hsl_due_q [$];
  int              errors = 0;

  function automatic rthc_hsl_t rgb_to_hsl(rthc_pixel_t px, logic [CH_W-1:0] thr);
    logic [63:0] r, g, b, hi, lo, spread, sum, den, sat, num, full;
    rthc_hsl_t   hsl;
    full = 64'(CH_FULL);
    r    = 64'(px.red);
    g    = 64'(px.green);
    b    = 64'(px.blue);
    hi   = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo   = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    spread = hi - lo;
    sum    = hi + lo;
    hsl.lightness = CH_W'(sum >> 1);
    if (spread <= 64'(thr)) begin
      hsl.hue        = '0;
      hsl.saturation = '0;
      return hsl;
    end
    den = (sum > full) ? (2 * full - sum) : sum;
    sat = (den == 0) ? full : (spread * full) / den;
    if (sat > full) sat = full;
    if (hi == r) begin
      num = (g >= b) ? (g - b) : (6 * spread - (b - g));
    end else if (hi == g) begin
      num = 2 * spread + b - r;
    end else begin
      num = 4 * spread + r - g;
    end
    hsl.hue        = CH_W'((num << CH_W) / (6 * spread));
    hsl.saturation = CH_W'(sat);
    return hsl;
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= MAX_LINES) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rthc_hsl_t want;
    if (!rst_ni) begin
      hsl_due_q.delete();
      gray_thr   = '0;
      err_cnt_o <= errors;
      due_cnt_o <= 0;
    end else begin
      if (cfg_we_i) gray_thr = CH_W'(cfg_wdata_i);
      if (out_valid_i && !out_stall_i) begin
        if (hsl_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected HSL word h=%0d s=%0d l=%0d",
                                  out_hsl_i.hue, out_hsl_i.saturation,
                                  out_hsl_i.lightness));
        end else begin
          want = hsl_due_q.pop_front();
          if (out_hsl_i.hue !== want.hue)
            flag_mismatch($sformatf("hue: expected %0d, got %0d",
                                    want.hue, out_hsl_i.hue));
          if (out_hsl_i.saturation !== want.saturation)
            flag_mismatch($sformatf("saturation: expected %0d, got %0d",
                                    want.saturation, out_hsl_i.saturation));
          if (out_hsl_i.lightness !== want.lightness)
            flag_mismatch($sformatf("lightness: expected %0d, got %0d",
                                    want.lightness, out_hsl_i.lightness));
        end
      end
      if (in_valid_i && !in_stall_i) hsl_due_q.push_back(rgb_to_hsl(in_pixel_i, gray_thr));
      err_cnt_o <= errors;
      due_cnt_o <= hsl_due_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the RGB to HSL core: corner pixels, gray threshold boundary
// pixels, then random pixels under several thresholds from zero to full
// scale. The sender works in bursts, the receiver stalls in changing
// patterns with periodic long holds. Checking is done by rthc_hsl_checker.
// ----------------------------------------------------------------------------
module tb;
  import rthc_pkg::*;

  localparam int CH_MAX  = (1 << CH_W) - 1;
  localparam int TIMEOUT = 3000000;

  typedef enum int {
    PX_UNIFORM,
    PX_EXTREME,
    PX_TIE,
    PX_NEAR_GRAY,
    PX_MID_SUM
  } px_kind_e;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PULSE
  } rx_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [THR_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  rthc_pixel_t       in_pixel_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rthc_hsl_t         out_hsl_o;
  int                err_cnt;
  int                due_cnt;
  int                burst_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_to_hsl_convert_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_hsl_o   (out_hsl_o)
  );

  rthc_hsl_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_hsl_i   (out_hsl_o),
    .err_cnt_o   (err_cnt),
    .due_cnt_o   (due_cnt)
  );

  function automatic rthc_pixel_t rgb(int r, int g, int b);
    return {CH_W'(r), CH_W'(g), CH_W'(b)};
  endfunction

  function automatic rthc_pixel_t shuffle_px(int a, int b, int c);
    case ($urandom_range(0, 5))
      0: return rgb(a, b, c);
      1: return rgb(a, c, b);
      2: return rgb(b, a, c);
      3: return rgb(b, c, a);
      4: return rgb(c, a, b);
      default: return rgb(c, b, a);
    endcase
  endfunction

  function automatic rthc_pixel_t random_pixel(logic [CH_W-1:0] thr);
    logic [CH_W-1:0] ch [3];
    int              s, lo, hi;
    case (px_kind_e'($urandom_range(0, 4)))
      PX_UNIFORM: begin
        return {CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
      end
      PX_EXTREME: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 3))
            0: ch[i] = '0;
            1: ch[i] = CH_W'(1);
            2: ch[i] = CH_FULL - 1'b1;
            default: ch[i] = CH_FULL;
          endcase
        end
        return {ch[0], ch[1], ch[2]};
      end
      PX_TIE: begin
        lo = $urandom_range(0, CH_MAX);
        hi = $urandom_range(0, CH_MAX);
        if ($urandom_range(0, 3) == 0) return rgb(lo, lo, lo);
        return shuffle_px(lo, lo, hi);
      end
      PX_NEAR_GRAY: begin
        s = int'(thr) + int'($urandom_range(0, 2)) - 1;
        if (s < 0) s = 0;
        if (s > CH_MAX) s = CH_MAX;
        lo = $urandom_range(0, CH_MAX - s);
        return shuffle_px(lo, lo + s, lo + int'($urandom_range(0, s)));
      end
      default: begin
        hi = $urandom_range(CH_MAX / 2 + 1, CH_MAX);
        lo = CH_MAX - hi + int'($urandom_range(0, 1));
        if (lo > hi) lo = hi;
        return shuffle_px(hi, lo, $urandom_range(lo, hi));
      end
    endcase
  endfunction

  task automatic send_pixel(input rthc_pixel_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_pixel_i = px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (due_cnt != 0) @(posedge clk_i);
  endtask

  task automatic set_gray_threshold(input logic [THR_W-1:0] thr);
    drain_pipeline();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = thr;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // receiver: changing stall patterns plus a periodic long hold
  initial begin
    rx_mode_e mode;
    int       left, hold, cyc;
    mode = RX_FREE;
    left = 0;
    hold = 0;
    cyc  = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold == 0 && cyc % 700 == 350) hold = 120;
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 150);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_stall_i = 1'b1;
      end else begin
        case (mode)
          RX_FREE:  out_stall_i = 1'b0;
          RX_LIGHT: out_stall_i = ($urandom_range(0, 9) < 3);
          RX_HEAVY: out_stall_i = ($urandom_range(0, 9) < 7);
          default:  out_stall_i = (cyc % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rthc_pixel_t     corner_q [$];
    rthc_pixel_t     edge_q [$];
    logic [CH_W-1:0] thr_set [5];
    int              run_len [5];

    corner_q.push_back(rgb(0, 0, 0));
    corner_q.push_back(rgb(CH_MAX, CH_MAX, CH_MAX));
    corner_q.push_back(rgb(CH_MAX, 0, 0));
    corner_q.push_back(rgb(0, CH_MAX, 0));
    corner_q.push_back(rgb(0, 0, CH_MAX));
    corner_q.push_back(rgb(CH_MAX, CH_MAX, 0));
    corner_q.push_back(rgb(0, CH_MAX, CH_MAX));
    corner_q.push_back(rgb(CH_MAX, 0, CH_MAX));
    corner_q.push_back(rgb(CH_MAX, 0, 1));
    corner_q.push_back(rgb(CH_MAX, 1, 0));
    corner_q.push_back(rgb(1, 0, 0));
    corner_q.push_back(rgb(0, 1, 0));
    corner_q.push_back(rgb(0, 0, 1));
    corner_q.push_back(rgb(CH_MAX, 0, 100));
    corner_q.push_back(rgb(CH_MAX, 1, 1));
    corner_q.push_back(rgb(32768, 32767, 32767));
    corner_q.push_back(rgb(32769, 32767, 32768));
    corner_q.push_back(rgb(12345, 54321, 40000));
    corner_q.push_back(rgb(CH_MAX, CH_MAX, CH_MAX - 1));
    edge_q.push_back(rgb(1000, 1100, 1050));
    edge_q.push_back(rgb(1000, 1101, 1050));
    edge_q.push_back(rgb(0, 100, 0));
    edge_q.push_back(rgb(0, 101, 0));

    thr_set[0] = CH_W'($urandom_range(1, 255));
    thr_set[1] = '0;
    thr_set[2] = CH_W'($urandom_range(256, CH_MAX - 1));
    thr_set[3] = CH_FULL;
    thr_set[4] = CH_FULL - 1'b1;
    run_len    = '{300, 350, 250, 100, 250};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (corner_q[i]) send_pixel(corner_q[i]);
    set_gray_threshold(THR_W'(100));
    foreach (edge_q[i]) send_pixel(edge_q[i]);

    for (int k = 0; k < 5; k++) begin
      set_gray_threshold(THR_W'(thr_set[k]));
      repeat (run_len[k]) send_pixel(random_pixel(thr_set[k]));
    end

    drain_pipeline();
    repeat (2 * NSTG) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
